FILE: design/usb_c_sink_attach_controller_defines.svh
// Assertion helpers used by the attach controller state machine (usbcsa_fsm).
// The macros expect clk_i, and USBCSA_ASSERT also rst_ni, in the scope where they are used.
`ifndef USB_C_SINK_ATTACH_CONTROLLER_DEFINES_SVH
`define USB_C_SINK_ATTACH_CONTROLLER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define USBCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define USBCSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/usbcsa_pkg.sv
// ----------------------------------------------------------------------------
// usbcsa_pkg
// Shared codes and types of the USB-C sink attach controller.
// ----------------------------------------------------------------------------
package usbcsa_pkg;

  // Attach mode codes
  localparam logic [1:0] MODE_UNATTACHED = 2'd0;
  localparam logic [1:0] MODE_MEAS_CC1   = 2'd1;
  localparam logic [1:0] MODE_MEAS_CC2   = 2'd2;
  localparam logic [1:0] MODE_ATTACHED   = 2'd3;

  // CC pin codes
  localparam logic [1:0] PIN_NONE = 2'd0;
  localparam logic [1:0] PIN_CC1  = 2'd1;
  localparam logic [1:0] PIN_CC2  = 2'd2;

  localparam logic [1:0] CC_LEVEL_OPEN = 2'd0;

  typedef struct packed {
    logic step;   // take one level sample
    logic clear;  // drop any held reference
  } dbnc_ctrl_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic [1:0] measure_pin;
    logic [1:0] transmit_pin;
    logic       auto_crc_on;
    logic       oscillator_on;
    logic [1:0] level_cc1;
    logic [1:0] level_cc2;
    logic       ev_attached;
    logic       ev_detached;
    logic       ev_good_crc;
    logic       ev_rx_message;
    logic       pd_reset_request;
  } result_t;

endpackage

FILE: design/usb_c_sink_attach_controller.sv
// A result is registered and valid in the cycle after its sample transaction is accepted.
// Throughput: one sample per cycle; the single result register sets the pace,
// taking a new sample whenever its held result is empty or leaves that cycle.
// Reset (rst_ni, async, active low): unattached, levels and filter cleared,
// VBUS detach enabled, no result held.
// ----------------------------------------------------------------------------
// usb_c_sink_attach_controller
// USB Type-C sink attach sequence: VBUS detect, debounced CC1/CC2 levels,
// transmit pin selection and attached-state events.
// ----------------------------------------------------------------------------
module usb_c_sink_attach_controller #(
  parameter int VERIFY_SAMPLES = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       vbus_ok_i,
  input  logic [1:0] cc_level_i,
  input  logic       hard_reset_seen_i,
  input  logic       good_crc_sent_i,
  input  logic       rx_not_empty_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] mode_now_o,
  output logic [1:0] measure_pin_o,
  output logic [1:0] transmit_pin_o,
  output logic       auto_crc_on_o,
  output logic       oscillator_on_o,
  output logic [1:0] level_cc1_o,
  output logic [1:0] level_cc2_o,
  output logic       ev_attached_o,
  output logic       ev_detached_o,
  output logic       ev_good_crc_o,
  output logic       ev_rx_message_o,
  output logic       pd_reset_request_o
);
  import usbcsa_pkg::*;

  logic    accept;
  result_t res_d;
  result_t res_q;

  assign accept = in_valid_i && in_ready_o;

  usbcsa_fsm #(
    .VERIFY_SAMPLES(VERIFY_SAMPLES)
  ) u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .vbus_ok_i        (vbus_ok_i),
    .cc_level_i       (cc_level_i),
    .hard_reset_seen_i(hard_reset_seen_i),
    .good_crc_sent_i  (good_crc_sent_i),
    .rx_not_empty_i   (rx_not_empty_i),
    .res_o            (res_d)
  );

  usbcsa_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res_d),
    .ready_o    (in_ready_o),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_q)
  );

  assign mode_now_o         = res_q.mode_now;
  assign measure_pin_o      = res_q.measure_pin;
  assign transmit_pin_o     = res_q.transmit_pin;
  assign auto_crc_on_o      = res_q.auto_crc_on;
  assign oscillator_on_o    = res_q.oscillator_on;
  assign level_cc1_o        = res_q.level_cc1;
  assign level_cc2_o        = res_q.level_cc2;
  assign ev_attached_o      = res_q.ev_attached;
  assign ev_detached_o      = res_q.ev_detached;
  assign ev_good_crc_o      = res_q.ev_good_crc;
  assign ev_rx_message_o    = res_q.ev_rx_message;
  assign pd_reset_request_o = res_q.pd_reset_request;

endmodule

FILE: design/usbcsa_debounce.sv
// ----------------------------------------------------------------------------
// usbcsa_debounce
// CC level filter: a reference sample followed by VERIFY_SAMPLES equal
// samples accepts the level; a mismatch drops the reference.
// ----------------------------------------------------------------------------
module usbcsa_debounce #(
  parameter int VERIFY_SAMPLES = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  usbcsa_pkg::dbnc_ctrl_t ctrl_i,
  input  logic [1:0]             level_i,
  output logic                   done_o,
  output logic [1:0]             level_o
);
  import usbcsa_pkg::*;

  localparam int CntW = $clog2(VERIFY_SAMPLES + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(VERIFY_SAMPLES - 1);

  logic [1:0]      ref_q, ref_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            valid_q, valid_d;

  always_comb begin
    ref_d   = ref_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    done_o  = 1'b0;
    if (ctrl_i.clear) begin
      cnt_d   = '0;
      valid_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (!valid_q) begin
        ref_d   = level_i;
        cnt_d   = '0;
        valid_d = 1'b1;
      end else if (level_i != ref_q) begin
        // drop the mismatching sample; the next one becomes the reference
        cnt_d   = '0;
        valid_d = 1'b0;
      end else if (cnt_q == CntLast) begin
        done_o  = 1'b1;
        cnt_d   = '0;
        valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign level_o = ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= CC_LEVEL_OPEN;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      ref_q   <= ref_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: design/usbcsa_fsm.sv
// ----------------------------------------------------------------------------
// usbcsa_fsm
// Attach state machine, stored CC levels, GoodCRC pending flag and the
// detach enable register; forms the result of each accepted sample.
// ----------------------------------------------------------------------------
`include "usb_c_sink_attach_controller_defines.svh"

module usbcsa_fsm #(
  parameter int VERIFY_SAMPLES = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                accept_i,
  input  logic                vbus_ok_i,
  input  logic [1:0]          cc_level_i,
  input  logic                hard_reset_seen_i,
  input  logic                good_crc_sent_i,
  input  logic                rx_not_empty_i,
  output usbcsa_pkg::result_t res_o
);
  import usbcsa_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic [1:0] cc1_q, cc1_d;
  logic [1:0] cc2_q, cc2_d;
  logic       gcrc_pend_q, gcrc_pend_d;
  logic       detach_en_q;

  dbnc_ctrl_t dbnc_ctrl;
  logic       dbnc_done;
  logic [1:0] dbnc_level;

  logic       ev_att, ev_det, ev_crc, ev_rx, pdr;
  logic [1:0] tx_pin;

  usbcsa_debounce #(
    .VERIFY_SAMPLES(VERIFY_SAMPLES)
  ) u_debounce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dbnc_ctrl),
    .level_i(cc_level_i),
    .done_o (dbnc_done),
    .level_o(dbnc_level)
  );

  always_comb begin
    logic gcrc_seen;
    gcrc_seen   = gcrc_pend_q | good_crc_sent_i;
    mode_d      = mode_q;
    cc1_d       = cc1_q;
    cc2_d       = cc2_q;
    gcrc_pend_d = gcrc_pend_q;
    dbnc_ctrl   = '0;
    ev_att      = 1'b0;
    ev_det      = 1'b0;
    ev_crc      = 1'b0;
    ev_rx       = 1'b0;
    pdr         = 1'b0;
    if (accept_i) begin
      case (mode_q)
        MODE_UNATTACHED: begin
          if (vbus_ok_i) begin
            mode_d          = MODE_MEAS_CC1;
            dbnc_ctrl.clear = 1'b1;
          end
        end
        MODE_MEAS_CC1: begin
          dbnc_ctrl.step = 1'b1;
          if (dbnc_done) begin
            cc1_d  = dbnc_level;
            mode_d = MODE_MEAS_CC2;
          end
        end
        MODE_MEAS_CC2: begin
          dbnc_ctrl.step = 1'b1;
          if (dbnc_done) begin
            cc2_d       = dbnc_level;
            mode_d      = MODE_ATTACHED;
            gcrc_pend_d = 1'b0;
            ev_att      = 1'b1;
          end
        end
        default: begin
          if (detach_en_q && !vbus_ok_i) begin
            mode_d      = MODE_UNATTACHED;
            gcrc_pend_d = gcrc_seen;
            ev_det      = 1'b1;
          end else if (hard_reset_seen_i) begin
            // hold a GoodCRC seen here for a later sample
            gcrc_pend_d = gcrc_seen;
            pdr         = 1'b1;
          end else begin
            gcrc_pend_d = 1'b0;
            ev_crc      = gcrc_seen;
            ev_rx       = rx_not_empty_i;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (mode_d != MODE_ATTACHED) begin
      tx_pin = PIN_NONE;
    end else if (cc1_d != CC_LEVEL_OPEN) begin
      tx_pin = PIN_CC1;
    end else if (cc2_d != CC_LEVEL_OPEN) begin
      tx_pin = PIN_CC2;
    end else begin
      tx_pin = PIN_NONE;
    end
  end

  always_comb begin
    res_o.mode_now         = mode_d;
    case (mode_d)
      MODE_MEAS_CC1: res_o.measure_pin = PIN_CC1;
      MODE_MEAS_CC2: res_o.measure_pin = PIN_CC2;
      MODE_ATTACHED: res_o.measure_pin = tx_pin;
      default:       res_o.measure_pin = PIN_NONE;
    endcase
    res_o.transmit_pin     = tx_pin;
    res_o.auto_crc_on      = (tx_pin != PIN_NONE);
    res_o.oscillator_on    = (mode_d != MODE_UNATTACHED);
    res_o.level_cc1        = cc1_d;
    res_o.level_cc2        = cc2_d;
    res_o.ev_attached      = ev_att;
    res_o.ev_detached      = ev_det;
    res_o.ev_good_crc      = ev_crc;
    res_o.ev_rx_message    = ev_rx;
    res_o.pd_reset_request = pdr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNATTACHED;
      cc1_q       <= CC_LEVEL_OPEN;
      cc2_q       <= CC_LEVEL_OPEN;
      gcrc_pend_q <= 1'b0;
      detach_en_q <= 1'b1;
    end else begin
      mode_q      <= mode_d;
      cc1_q       <= cc1_d;
      cc2_q       <= cc2_d;
      gcrc_pend_q <= gcrc_pend_d;
      if (cfg_we_i) begin
        detach_en_q <= cfg_wdata_i;
      end
    end
  end

  `USBCSA_ASSERT(a_mode_holds_when_idle, !accept_i |=> $stable(mode_q), "mode moved without a transaction")
  `USBCSA_ASSERT(a_cc2_done_attaches, (accept_i && mode_q == MODE_MEAS_CC2 && dbnc_done) |=> (mode_q == MODE_ATTACHED), "accepted CC2 level did not attach")
  `USBCSA_ASSERT(a_no_vbus_stays_unattached, (accept_i && mode_q == MODE_UNATTACHED && !vbus_ok_i) |=> (mode_q == MODE_UNATTACHED), "left unattached without VBUS")
  `USBCSA_ASSERT_ALWAYS(a_dbnc_only_measuring, dbnc_done |-> (mode_q == MODE_MEAS_CC1 || mode_q == MODE_MEAS_CC2), "level accepted outside measurement")

endmodule

FILE: design/usbcsa_out_reg.sv
// ----------------------------------------------------------------------------
// usbcsa_out_reg
// Result register with valid flag; takes a new result whenever the held
// one is empty or leaves in the same cycle.
// ----------------------------------------------------------------------------
module usbcsa_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  usbcsa_pkg::result_t res_i,
  output logic                ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output usbcsa_pkg::result_t res_o
);
  import usbcsa_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule
